@@ sv/ffca_pkg.sv @@
// Shared types and codes for the floor-control arbiter.
// Used by ffca_entry_eval and fifo_floor_control_arbiter; depends on nothing.
package ffca_pkg;

    // Client slots; the 3-bit slot fields address exactly this many
    localparam int NUM_SLOTS = 8;

    typedef enum logic [1:0] {
        CMD_JOIN  = 2'd0,
        CMD_REQ   = 2'd1,
        CMD_REL   = 2'd2,
        CMD_LEAVE = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_DONE    = 3'd0,
        ST_IGNORED = 3'd1,
        ST_OWNER   = 3'd2,
        ST_QUEUED  = 3'd3,
        ST_NO_SLOT = 3'd4
    } t_status;

    // What a walk over the wait queue is for
    typedef enum logic [1:0] {
        PM_DUP   = 2'd0,
        PM_POP   = 2'd1,
        PM_LEAVE = 2'd2
    } t_scan_mode;

    typedef struct packed {
        logic match;
        logic active;
        logic keep;
    } t_eval;

endpackage

@@ sv/ffca_entry_eval.sv @@
// Shared compare unit: judges one wait-queue entry against the current command.
// Depends on ffca_pkg.
module ffca_entry_eval (
    input  ffca_pkg::t_scan_mode i_mode,
    input  logic [2:0]           i_entry,
    input  logic [2:0]           i_client,
    input  logic [7:0]           i_mask8,
    input  logic                 i_first,
    output ffca_pkg::t_eval      o_eval
);
    import ffca_pkg::*;

    always_comb begin
        o_eval.match  = (i_entry == i_client);
        o_eval.active = i_mask8[i_entry];
        case (i_mode)
            PM_POP:   o_eval.keep = !i_first;
            PM_LEAVE: o_eval.keep = !o_eval.match && o_eval.active;
            default:  o_eval.keep = 1'b0;
        endcase
    end

endmodule

@@ sv/fifo_floor_control_arbiter.sv @@
// Floor-control arbiter: one owner among NUM_SLOTS client slots, with an ordered wait queue.
// Depends on ffca_pkg and ffca_entry_eval.
//
// One command is taken at a time; o_stall stays high until its result is registered. A join
// walks the slot mask one slot a cycle until it finds a free slot or passes the last one.
// A request that must queue, a release with a non-empty queue and a leave walk the wait queue
// through its single read port, one entry a cycle; each entry is read through a register before it
// is judged, and a closing step follows. An owner leave that finds no usable queue head then walks
// the slot mask for the lowest active slot. Commands that end at once go straight to the closing
// state. The next command is accepted while the previous result still waits on i_stall.
module fifo_floor_control_arbiter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_command,
    input  logic [2:0] i_client,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_status,
    output logic [2:0] o_slot,
    output logic       o_has_owner,
    output logic [2:0] o_owner,
    output logic [3:0] o_queue_position,
    output logic [3:0] o_queue_length
);
    import ffca_pkg::*;

    localparam int SW   = $clog2(NUM_SLOTS);
    localparam int CNTW = $clog2(NUM_SLOTS + 1);
    localparam int MW   = (NUM_SLOTS > 8) ? NUM_SLOTS : 8;
    localparam int OW   = (SW > 3) ? SW : 3;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_JOIN = 6'b000010,
        S_SCAN = 6'b000100,
        S_OWN  = 6'b001000,
        S_FIN  = 6'b010000,
        S_SPARE = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [2:0]        r_cli, n_cli;
    logic [NUM_SLOTS-1:0] r_active, n_active;
    logic              r_own_vld, n_own_vld;
    logic [SW-1:0]     r_owner, n_owner;
    logic [CNTW-1:0]   r_count, n_count;
    logic [CNTW-1:0]   r_idx, n_idx;
    logic [CNTW-1:0]   r_wi, n_wi;
    logic              r_pv, n_pv;
    logic              r_pfirst, n_pfirst;
    logic              r_dup, n_dup;
    logic [2:0]        r_head, n_head;
    t_scan_mode        r_mode, n_mode;
    t_status           r_status, n_status;
    logic [2:0]        r_slot, n_slot;
    logic [CNTW-1:0]   r_qpos, n_qpos;

    logic [2:0]        r_wait_mem [NUM_SLOTS];
    logic [2:0]        r_rd_data;
    logic              w_we;
    logic [SW-1:0]     w_waddr;
    logic [2:0]        w_wdata;

    logic [MW-1:0]     w_mask_ext;
    logic [7:0]        w_mask8;
    logic              w_cli_act;
    logic              w_own_is_cli;
    logic              w_own_is_rcli;
    logic              w_load;
    t_eval             w_eval;

    logic              r_out_vld;
    t_status           r_o_status;
    logic [2:0]        r_o_slot;
    logic              r_o_has_owner;
    logic [2:0]        r_o_owner;
    logic [3:0]        r_o_qpos;
    logic [3:0]        r_o_qlen;

    assign w_mask_ext    = MW'(r_active);
    assign w_mask8       = w_mask_ext[7:0];
    assign w_cli_act     = w_mask8[i_client];
    assign w_own_is_cli  = r_own_vld && (OW'(r_owner) == OW'(i_client));
    assign w_own_is_rcli = r_own_vld && (OW'(r_owner) == OW'(r_cli));

    ffca_entry_eval u_eval (
        .i_mode   (r_mode),
        .i_entry  (r_rd_data),
        .i_client (r_cli),
        .i_mask8  (w_mask8),
        .i_first  (r_pfirst),
        .o_eval   (w_eval)
    );

    assign o_stall = (r_state != S_IDLE);
    assign w_load  = (r_state == S_FIN) && (!r_out_vld || !i_stall);

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_cli     = r_cli;
        n_active  = r_active;
        n_own_vld = r_own_vld;
        n_owner   = r_owner;
        n_count   = r_count;
        n_idx     = r_idx;
        n_wi      = r_wi;
        n_pv      = 1'b0;
        n_pfirst  = 1'b0;
        n_dup     = r_dup;
        n_head    = r_head;
        n_mode    = r_mode;
        n_status  = r_status;
        n_slot    = r_slot;
        n_qpos    = r_qpos;
        w_we      = 1'b0;
        w_waddr   = r_count[SW-1:0];
        w_wdata   = r_cli;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd    = t_cmd'(i_command);
                    n_cli    = i_client;
                    n_status = ST_DONE;
                    n_slot   = i_client;
                    n_qpos   = '0;
                    n_idx    = '0;
                    n_wi     = '0;
                    n_dup    = 1'b0;
                    n_state  = S_FIN;
                    if (t_cmd'(i_command) == CMD_JOIN) begin
                        n_slot   = '0;
                        n_status = ST_NO_SLOT;
                        n_state  = S_JOIN;
                    end else if (!w_cli_act) begin
                        n_status = ST_IGNORED;
                    end else begin
                        case (t_cmd'(i_command))
                            CMD_REQ: begin
                                if (w_own_is_cli) begin
                                    n_status = ST_OWNER;
                                end else if (!r_own_vld) begin
                                    n_own_vld = 1'b1;
                                    n_owner   = SW'(i_client);
                                end else begin
                                    n_mode  = PM_DUP;
                                    n_state = S_SCAN;
                                end
                            end
                            CMD_REL: begin
                                if (!w_own_is_cli) begin
                                    n_status = ST_IGNORED;
                                end else begin
                                    n_own_vld = 1'b0;
                                    n_owner   = '0;
                                    if (r_count != '0) begin
                                        n_mode  = PM_POP;
                                        n_state = S_SCAN;
                                    end
                                end
                            end
                            default: begin
                                n_active = r_active & ~(NUM_SLOTS'(1) << i_client);
                                if (w_own_is_cli) begin
                                    n_own_vld = 1'b0;
                                    n_owner   = '0;
                                    if (r_count != '0) begin
                                        n_mode  = PM_POP;
                                        n_state = S_SCAN;
                                    end else begin
                                        n_state = S_OWN;
                                    end
                                end else begin
                                    n_mode  = PM_LEAVE;
                                    n_state = S_SCAN;
                                end
                            end
                        endcase
                    end
                end
            end
            S_JOIN: begin
                if (r_idx == CNTW'(NUM_SLOTS)) begin
                    n_state = S_FIN;
                end else if (!r_active[r_idx[SW-1:0]]) begin
                    n_active[r_idx[SW-1:0]] = 1'b1;
                    if (!r_own_vld) begin
                        n_own_vld = 1'b1;
                        n_owner   = r_idx[SW-1:0];
                    end
                    n_status = ST_DONE;
                    n_slot   = 3'(r_idx);
                    n_state  = S_FIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_OWN: begin
                if (r_idx == CNTW'(NUM_SLOTS)) begin
                    n_state = S_FIN;
                end else if (r_active[r_idx[SW-1:0]]) begin
                    n_own_vld = 1'b1;
                    n_owner   = r_idx[SW-1:0];
                    n_state   = S_FIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_SCAN: begin
                // issue the next read while the previous beat of data is judged
                if (r_idx < r_count) begin
                    n_idx    = r_idx + 1'b1;
                    n_pv     = 1'b1;
                    n_pfirst = (r_idx == '0);
                end
                if (r_pv) begin
                    if (r_mode == PM_DUP) begin
                        if (w_eval.match) n_dup = 1'b1;
                    end else begin
                        if (r_pfirst) n_head = r_rd_data;
                        if (w_eval.keep) begin
                            w_we    = 1'b1;
                            w_waddr = r_wi[SW-1:0];
                            w_wdata = r_rd_data;
                            n_wi    = r_wi + 1'b1;
                        end
                    end
                end else if (r_idx == r_count) begin
                    n_state = S_FIN;
                    n_idx   = '0;
                    case (r_mode)
                        PM_DUP: begin
                            if (r_dup) begin
                                n_status = ST_QUEUED;
                            end else if (r_count >= CNTW'(NUM_SLOTS)) begin
                                n_status = ST_IGNORED;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = r_count[SW-1:0];
                                w_wdata = r_cli;
                                n_count = r_count + 1'b1;
                                n_qpos  = r_count + 1'b1;
                            end
                        end
                        PM_POP: begin
                            n_count = r_wi;
                            if (w_mask8[r_head]) begin
                                n_own_vld = 1'b1;
                                n_owner   = SW'(r_head);
                            end else if (r_cmd == CMD_LEAVE) begin
                                // fall back to the lowest active slot
                                n_state = S_OWN;
                            end
                        end
                        default: begin
                            n_count = r_wi;
                        end
                    endcase
                end
            end
            S_FIN: begin
                if (w_load) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_active  <= '0;
            r_own_vld <= 1'b0;
            r_owner   <= '0;
            r_count   <= '0;
            r_pv      <= 1'b0;
            r_pfirst  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_active  <= n_active;
            r_own_vld <= n_own_vld;
            r_owner   <= n_owner;
            r_count   <= n_count;
            r_pv      <= n_pv;
            r_pfirst  <= n_pfirst;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_cli    <= n_cli;
        r_idx    <= n_idx;
        r_wi     <= n_wi;
        r_dup    <= n_dup;
        r_head   <= n_head;
        r_mode   <= n_mode;
        r_status <= n_status;
        r_slot   <= n_slot;
        r_qpos   <= n_qpos;
    end

    // Wait queue: one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (w_we) r_wait_mem[w_waddr] <= w_wdata;
        r_rd_data <= r_wait_mem[r_idx[SW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_status    <= r_status;
            r_o_slot      <= r_slot;
            r_o_has_owner <= r_own_vld;
            r_o_owner     <= r_own_vld ? 3'(r_owner) : 3'd0;
            r_o_qpos      <= 4'(r_qpos);
            r_o_qlen      <= 4'(r_count);
        end
    end

    assign o_valid          = r_out_vld;
    assign o_status         = r_o_status;
    assign o_slot           = r_o_slot;
    assign o_has_owner      = r_o_has_owner;
    assign o_owner          = r_o_owner;
    assign o_queue_position = r_o_qpos;
    assign o_queue_length   = r_o_qlen;

endmodule
